// ===== rtl/stms_pkg.sv =====
// Package for the segment tree min/max search core.
// Holds the node type, the field widths, sentinels and operation codes.
// No dependencies.
`default_nettype none

package stms_pkg;

    localparam int DATA_W = 31;
    localparam int POS_W  = 10;
    localparam int OP_W   = 2;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_RMIN  = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND  = 2'd2;

    localparam logic signed [DATA_W-1:0] BIG_POS = 31'sd1000000000;
    localparam logic signed [DATA_W-1:0] BIG_NEG = -31'sd1000000000;

    typedef struct packed {
        logic signed [DATA_W-1:0] mn;
        logic signed [DATA_W-1:0] mx;
    } t_node;

endpackage

`default_nettype wire

// ===== rtl/stms_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`default_nettype none

module stms_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/segment_tree_min_max_search_core.sv =====
// Segment tree min/max search core: point write, range minimum, first-at-least search.
// The node RAM has one write port and one read port, one read a cycle.
// One item at a time: busy stays high until the item is done; results cannot stall.
// Reset: synchronous; a clearing pass over all 2*LEAVES nodes follows, busy meanwhile.
// Depends on stms_pkg and stms_ram.
`default_nettype none

module segment_tree_min_max_search_core #(
    parameter int LEAVES = 1024
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    input  wire logic [stms_pkg::OP_W-1:0]          i_op,
    input  wire logic [stms_pkg::POS_W-1:0]         i_pos_a,
    input  wire logic [stms_pkg::POS_W-1:0]         i_pos_b,
    input  wire logic signed [stms_pkg::DATA_W-1:0] i_value,
    output      logic                               busy,
    output      logic                               o_valid,
    output      logic signed [stms_pkg::DATA_W-1:0] o_answer
);

    localparam int LW = $clog2(LEAVES);
    localparam int NW = LW + 1;
    localparam int CW = (NW > stms_pkg::POS_W) ? NW : stms_pkg::POS_W;
    localparam int DW = stms_pkg::DATA_W;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WR     = 4'd2;
    localparam logic [3:0] S_RM_L   = 4'd3;
    localparam logic [3:0] S_RM_R   = 4'd4;
    localparam logic [3:0] S_UP_RD  = 4'd5;
    localparam logic [3:0] S_UP_CHK = 4'd6;
    localparam logic [3:0] S_DN_RD  = 4'd7;
    localparam logic [3:0] S_DN_CHK = 4'd8;

    localparam logic [CW-1:0] POS_ONE  = CW'(1);
    localparam logic [CW-1:0] POS_LIM  = CW'(LEAVES - 2);
    localparam logic [CW-1:0] POS_LEAF = CW'(LEAVES);
    localparam logic [NW-1:0] K_ONE    = NW'(1);

    logic [3:0]              r_state, n_state;
    logic [NW-1:0]           r_k, n_k;
    logic [NW-1:0]           r_rp, n_rp;
    stms_pkg::t_node         r_cur, n_cur;
    logic signed [DW-1:0]    r_thr, n_thr;
    logic                    r_pend, n_pend;
    logic                    r_valid, n_valid;
    logic signed [DW-1:0]    r_answer, n_answer;

    logic                    ram_we;
    logic [NW-1:0]           ram_waddr;
    stms_pkg::t_node         ram_wdata;
    logic [NW-1:0]           ram_raddr;
    stms_pkg::t_node         ram_rdata;

    logic [CW-1:0]           a_ext, b_ext, a_c, b_c;
    logic                    rm_empty, wr_ok, fd_none;
    logic [NW-1:0]           leaf_a, lp0, rp0, parent;
    logic signed [DW-1:0]    acc;
    stms_pkg::t_node         comb;

    stms_ram #(
        .WIDTH ($bits(stms_pkg::t_node)),
        .DEPTH (2 * LEAVES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        a_ext    = CW'(i_pos_a);
        b_ext    = CW'(i_pos_b);
        a_c      = (a_ext == '0) ? POS_ONE : a_ext;
        b_c      = (b_ext > POS_LIM) ? POS_LIM : b_ext;
        rm_empty = a_c > b_c;
        wr_ok    = (a_ext != '0) && (a_ext <= POS_LIM);
        fd_none  = a_c >= POS_LEAF;
        leaf_a   = {1'b1, a_c[LW-1:0]};
        lp0      = leaf_a - K_ONE;
        rp0      = {1'b1, b_c[LW-1:0]} + K_ONE;
        parent   = r_k >> 1;
        acc      = (r_pend && (ram_rdata.mn < r_cur.mn)) ? ram_rdata.mn : r_cur.mn;
        comb.mn  = (ram_rdata.mn < r_cur.mn) ? ram_rdata.mn : r_cur.mn;
        comb.mx  = (ram_rdata.mx > r_cur.mx) ? ram_rdata.mx : r_cur.mx;
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_rp      = r_rp;
        n_cur     = r_cur;
        n_thr     = r_thr;
        n_pend    = 1'b0;
        n_valid   = 1'b0;
        n_answer  = r_answer;
        ram_we    = 1'b0;
        ram_waddr = r_k;
        ram_wdata = r_cur;
        ram_raddr = r_k;

        unique case (r_state)
            S_CLR: begin
                ram_we       = 1'b1;
                ram_wdata.mn = stms_pkg::BIG_POS;
                ram_wdata.mx = stms_pkg::BIG_NEG;
                n_k          = r_k + K_ONE;
                if (r_k == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_op)
                        stms_pkg::OP_WRITE: begin
                            if (wr_ok) begin
                                ram_we       = 1'b1;
                                ram_waddr    = leaf_a;
                                ram_wdata.mn = i_value;
                                ram_wdata.mx = i_value;
                                ram_raddr    = leaf_a ^ K_ONE;
                                n_k          = leaf_a;
                                n_cur.mn     = i_value;
                                n_cur.mx     = i_value;
                                n_state      = S_WR;
                            end
                        end
                        stms_pkg::OP_RMIN: begin
                            if (rm_empty) begin
                                n_valid  = 1'b1;
                                n_answer = stms_pkg::BIG_POS;
                            end else begin
                                n_k      = lp0;
                                n_rp     = rp0;
                                n_cur.mn = stms_pkg::BIG_POS;
                                n_state  = S_RM_L;
                            end
                        end
                        stms_pkg::OP_FIND: begin
                            if (fd_none) begin
                                n_valid  = 1'b1;
                                n_answer = '0;
                            end else begin
                                n_k     = lp0;
                                n_thr   = i_value;
                                n_state = S_UP_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WR: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = comb;
                ram_raddr = parent ^ K_ONE;
                n_cur     = comb;
                n_k       = parent;
                if (parent == K_ONE) begin
                    n_state = S_IDLE;
                end
            end
            S_RM_L: begin
                n_cur.mn = acc;
                if ((r_k ^ r_rp ^ K_ONE) == '0) begin
                    n_valid  = 1'b1;
                    n_answer = acc;
                    n_state  = S_IDLE;
                end else begin
                    ram_raddr = r_k ^ K_ONE;
                    n_pend    = !r_k[0];
                    n_state   = S_RM_R;
                end
            end
            S_RM_R: begin
                n_cur.mn  = acc;
                ram_raddr = r_rp ^ K_ONE;
                n_pend    = r_rp[0];
                n_k       = r_k >> 1;
                n_rp      = r_rp >> 1;
                n_state   = S_RM_L;
            end
            S_UP_RD: begin
                if (r_k == '0) begin
                    n_valid  = 1'b1;
                    n_answer = '0;
                    n_state  = S_IDLE;
                end else if (r_k[0]) begin
                    n_k = parent;
                end else begin
                    ram_raddr = r_k | K_ONE;
                    n_state   = S_UP_CHK;
                end
            end
            S_UP_CHK: begin
                if (ram_rdata.mx >= r_thr) begin
                    n_k     = r_k | K_ONE;
                    n_state = S_DN_RD;
                end else begin
                    n_k     = parent;
                    n_state = S_UP_RD;
                end
            end
            S_DN_RD: begin
                if (r_k[LW]) begin
                    n_valid  = 1'b1;
                    n_answer = {{(DW-LW){1'b0}}, r_k[LW-1:0]};
                    n_state  = S_IDLE;
                end else begin
                    ram_raddr = r_k << 1;
                    n_k       = r_k << 1;
                    n_state   = S_DN_CHK;
                end
            end
            S_DN_CHK: begin
                if (ram_rdata.mx < r_thr) begin
                    n_k = r_k | K_ONE;
                end
                n_state = S_DN_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_k     <= '0;
            r_pend  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_pend  <= n_pend;
            r_valid <= n_valid;
        end
        r_rp     <= n_rp;
        r_cur    <= n_cur;
        r_thr    <= n_thr;
        r_answer <= n_answer;
    end

    assign busy     = r_state != S_IDLE;
    assign o_valid  = r_valid;
    assign o_answer = r_answer;

endmodule

`default_nettype wire

// ===== rtl/stms_chk.sv =====
// Port-level checker for the segment tree min/max search core, bound to the top level.
// Depends on stms_pkg.
`default_nettype none

module stms_chk (
    input wire logic                               i_clk,
    input wire logic                               i_rst_n,
    input wire logic                               start,
    input wire logic [stms_pkg::OP_W-1:0]          i_op,
    input wire logic [stms_pkg::POS_W-1:0]         i_pos_a,
    input wire logic [stms_pkg::POS_W-1:0]         i_pos_b,
    input wire logic                               busy,
    input wire logic                               o_valid,
    input wire logic signed [stms_pkg::DATA_W-1:0] o_answer
);

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("no clearing pass after reset");

    a_no_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(busy) || $past(start)))
        else $error("result without an item");

    a_write_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == stms_pkg::OP_WRITE) |=> !o_valid)
        else $error("write gave a result");

    a_empty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_op == stms_pkg::OP_RMIN && i_pos_a > i_pos_b)
        |=> (o_valid && o_answer == stms_pkg::BIG_POS))
        else $error("empty range did not return the sentinel");

endmodule

bind segment_tree_min_max_search_core stms_chk u_stms_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .i_op     (i_op),
    .i_pos_a  (i_pos_a),
    .i_pos_b  (i_pos_b),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_answer (o_answer)
);

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for segment_tree_min_max_search_core.
// Directed table, then random writes, range minima and searches checked against a
// behavioral segment tree. Depends on stms_pkg and the core RTL.
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEAVES = 1024;
    localparam int DATA_W = stms_pkg::DATA_W;
    localparam int POS_W  = stms_pkg::POS_W;
    localparam int OP_W   = stms_pkg::OP_W;
    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = -31'sd1073741824;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 31'sd1073741823;
    localparam int RAND_ITEMS = 2000;
    localparam int DRAIN_CYCLES = 64;

    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic [POS_W-1:0]         a;
        logic [POS_W-1:0]         b;
        logic signed [DATA_W-1:0] v;
        logic                     fixed;
        logic signed [DATA_W-1:0] ans;
    } t_stim_row;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [OP_W-1:0]          i_op = stms_pkg::OP_WRITE;
    logic [POS_W-1:0]         i_pos_a = '0;
    logic [POS_W-1:0]         i_pos_b = '0;
    logic signed [DATA_W-1:0] i_value = '0;
    logic                     busy;
    logic                     o_valid;
    logic signed [DATA_W-1:0] o_answer;

    int tree_lo [2*LEAVES];
    int tree_hi [2*LEAVES];
    logic signed [DATA_W-1:0] pending_answers [$];
    t_stim_row directed_rows [$];
    int mismatch_cnt = 0;
    int idle_pct = 0;
    int recent_vals [8];

    segment_tree_min_max_search_core #(.LEAVES(LEAVES)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_op     (i_op),
        .i_pos_a  (i_pos_a),
        .i_pos_b  (i_pos_b),
        .i_value  (i_value),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_answer (o_answer)
    );

    always #5 i_clk = ~i_clk;

    function automatic void tree_write(int unsigned pos, int v);
        int unsigned k;
        if (pos < 1 || pos > LEAVES - 2) return;
        k = LEAVES + pos;
        tree_lo[k] = v;
        tree_hi[k] = v;
        for (k = k >> 1; k != 0; k = k >> 1) begin
            tree_lo[k] = (tree_lo[2*k] < tree_lo[2*k+1]) ? tree_lo[2*k] : tree_lo[2*k+1];
            tree_hi[k] = (tree_hi[2*k] > tree_hi[2*k+1]) ? tree_hi[2*k] : tree_hi[2*k+1];
        end
    endfunction

    function automatic int range_min(int unsigned a, int unsigned b);
        int best;
        int unsigned lp;
        int unsigned rp;
        best = stms_pkg::BIG_POS;
        if (a < 1) a = 1;
        if (b > LEAVES - 2) b = LEAVES - 2;
        if (a > b) return stms_pkg::BIG_POS;
        lp = LEAVES + a - 1;
        rp = LEAVES + b + 1;
        while ((lp ^ rp ^ 1) != 0) begin
            if (!lp[0] && tree_lo[lp ^ 1] < best) best = tree_lo[lp ^ 1];
            if (rp[0] && tree_lo[rp ^ 1] < best) best = tree_lo[rp ^ 1];
            lp = lp >> 1;
            rp = rp >> 1;
        end
        return best;
    endfunction

    function automatic int first_at_least(int unsigned a, int thr);
        int unsigned k;
        if (a < 1) a = 1;
        if (a >= LEAVES) return 0;
        for (k = LEAVES + a - 1; k != 0; k = k >> 1) begin
            if (!k[0] && tree_hi[k+1] >= thr) begin
                k = k + 1;
                while (k < LEAVES) begin
                    k = k << 1;
                    if (tree_hi[k] < thr) k = k + 1;
                end
                return k - LEAVES;
            end
        end
        return 0;
    endfunction

    // Drive one item; expectation is queued once acceptance at the next edge is certain.
    task automatic send_item(t_stim_row row);
        int pred;
        @(negedge i_clk);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= row.op;
        i_pos_a <= row.a;
        i_pos_b <= row.b;
        i_value <= row.v;
        while (busy !== 1'b0) @(negedge i_clk);
        pred = 0;
        case (row.op)
            stms_pkg::OP_WRITE: tree_write(row.a, row.v);
            stms_pkg::OP_RMIN:  pred = range_min(row.a, row.b);
            stms_pkg::OP_FIND:  pred = first_at_least(row.a, row.v);
            default: ;
        endcase
        if (row.op == stms_pkg::OP_RMIN || row.op == stms_pkg::OP_FIND)
            pending_answers.push_back(row.fixed ? row.ans : DATA_W'(pred));
    endtask

    task automatic add_row(logic [OP_W-1:0] op, int a, int b, logic signed [DATA_W-1:0] v,
                           logic fixed, logic signed [DATA_W-1:0] ans);
        t_stim_row r;
        r.op = op;
        r.a = POS_W'(a);
        r.b = POS_W'(b);
        r.v = v;
        r.fixed = fixed;
        r.ans = ans;
        directed_rows.push_back(r);
    endtask

    function automatic int rand_pos(int base, int span);
        int p;
        case ($urandom_range(0, 19))
            0: return 0;
            1: return LEAVES - 1;
            2: return 1;
            3: return LEAVES - 2;
            default: begin
                p = base + $urandom_range(0, span);
                return (p > LEAVES - 1) ? LEAVES - 1 : p;
            end
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return stms_pkg::BIG_POS;
            1: return stms_pkg::BIG_NEG;
            2: return VAL_MIN;
            3: return VAL_MAX;
            4, 5, 6: return DATA_W'($urandom_range(0, 2000)) - 31'sd1000;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_answers.size() == 0) begin
                mismatch_cnt <= mismatch_cnt + 1;
                $display("%0t unexpected answer: expected none actual %0d", $time, o_answer);
            end else begin
                if (o_answer !== pending_answers[0]) begin
                    mismatch_cnt <= mismatch_cnt + 1;
                    $display("%0t answer mismatch: expected %0d actual %0d",
                             $time, pending_answers[0], o_answer);
                end
                void'(pending_answers.pop_front());
            end
        end else if (i_rst_n && o_valid !== 1'b0) begin
            mismatch_cnt <= mismatch_cnt + 1;
            $display("%0t valid strobe: expected 0 actual %b", $time, o_valid);
        end
    end

    initial begin
        #10ms;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int counted;
        int base;
        int span;
        int pick;
        t_stim_row r;

        for (int i = 0; i < 2*LEAVES; i++) begin
            tree_lo[i] = stms_pkg::BIG_POS;
            tree_hi[i] = stms_pkg::BIG_NEG;
        end
        foreach (recent_vals[i]) recent_vals[i] = 0;

        // empty tree, bounds clamping, ignored writes and ops, sentinel hits
        add_row(stms_pkg::OP_RMIN,  1, LEAVES-2, '0, 1'b1, stms_pkg::BIG_POS);
        add_row(stms_pkg::OP_FIND,  1, 0,   '0, 1'b1, '0);
        add_row(stms_pkg::OP_FIND,  5, 0,   stms_pkg::BIG_NEG, 1'b1, 31'sd5);
        add_row(stms_pkg::OP_FIND,  0, 1023, stms_pkg::BIG_NEG, 1'b1, 31'sd1);
        add_row(stms_pkg::OP_FIND,  1023, 0, stms_pkg::BIG_NEG, 1'b1, 31'sd1023);
        add_row(stms_pkg::OP_WRITE, 0, 0,   31'sd5, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, 1023, 1023, -31'sd7, 1'b0, '0);
        add_row(stms_pkg::OP_RMIN,  0, 1023, '0, 1'b1, stms_pkg::BIG_POS);
        add_row(OP_NONE,            3, 3,   VAL_MAX, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, 1, 0,   VAL_MIN, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, LEAVES-2, 0, VAL_MAX, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, 512, 1023, '0, 1'b0, '0);
        add_row(stms_pkg::OP_RMIN,  0, 1023, '0, 1'b1, VAL_MIN);
        add_row(stms_pkg::OP_RMIN,  2, LEAVES-3, '0, 1'b0, '0);
        add_row(stms_pkg::OP_RMIN,  600, 100, '0, 1'b1, stms_pkg::BIG_POS);
        add_row(stms_pkg::OP_FIND,  2, 0,   VAL_MAX, 1'b0, '0);
        add_row(stms_pkg::OP_FIND,  0, 0,   31'sd1, 1'b0, '0);
        add_row(stms_pkg::OP_FIND,  513, 0, '0, 1'b0, '0);
        add_row(stms_pkg::OP_FIND,  1, 0,   VAL_MIN, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, 300, 0, stms_pkg::BIG_POS, 1'b0, '0);
        add_row(stms_pkg::OP_WRITE, 301, 0, stms_pkg::BIG_NEG, 1'b0, '0);
        add_row(stms_pkg::OP_RMIN,  300, 301, '0, 1'b0, '0);
        add_row(stms_pkg::OP_FIND,  300, 0, stms_pkg::BIG_POS, 1'b0, '0);
        add_row(stms_pkg::OP_RMIN,  LEAVES-2, LEAVES-2, '0, 1'b0, '0);
        add_row(stms_pkg::OP_FIND,  1023, 0, 31'sd5, 1'b0, '0);

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) send_item(directed_rows[i]);

        counted = 0;
        base = 1;
        span = 8;
        while (counted < RAND_ITEMS) begin
            case (counted * 3 / RAND_ITEMS)
                0: idle_pct = 38;
                1: idle_pct = 64;
                default: idle_pct = 0;
            endcase
            if ($urandom_range(0, 39) == 0) begin
                case ($urandom_range(0, 3))
                    0, 1: span = 8;
                    2: span = 64;
                    default: span = LEAVES - 2;
                endcase
                base = $urandom_range(0, LEAVES - 2 - ((span > 64) ? 0 : span));
                if (span > 64) base = 0;
            end
            r.fixed = 1'b0;
            r.ans = '0;
            r.a = POS_W'(rand_pos(base, span));
            r.b = POS_W'($urandom);
            r.v = rand_value();
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                r.op = stms_pkg::OP_WRITE;
                recent_vals[$urandom_range(0, 7)] = r.v;
            end else if (pick < 70) begin
                r.op = stms_pkg::OP_RMIN;
                if ($urandom_range(0, 9) != 0)
                    r.b = POS_W'(rand_pos(r.a, span));
            end else if (pick < 95) begin
                r.op = stms_pkg::OP_FIND;
                if ($urandom_range(0, 9) < 4)
                    r.v = DATA_W'(recent_vals[$urandom_range(0, 7)]);
            end else begin
                r.op = OP_NONE;
            end
            send_item(r);
            if (r.op != OP_NONE
                && !(r.op == stms_pkg::OP_WRITE && (r.a == 0 || r.a > LEAVES - 2)))
                counted++;
        end

        @(negedge i_clk);
        start <= 1'b0;
        while (pending_answers.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (mismatch_cnt == 0 && pending_answers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/stms_pkg.sv
rtl/stms_ram.sv
rtl/segment_tree_min_max_search_core.sv
rtl/stms_chk.sv
tb/sv/tb_top.sv
